// File: src/skt_pkg.sv
// Package for the sorted key table: operation and status codes, fixed field widths.
`default_nettype none
package skt_pkg;
	localparam int KEY_W       = 32;
	localparam int OUT_HDL_W   = 16;
	localparam int OUT_COUNT_W = 7;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic       shifting;
	} skt_op_t;
endpackage
`default_nettype wire

// File: src/skt_ram.sv
// Entry store: one write port, one read port with registered read data.
`default_nettype none
module skt_ram #(
	parameter int DEPTH  = 64,
	parameter int AW     = 6,
	parameter int WORD_W = 48
) (
	input  wire logic              clk,
	input  wire logic              wen,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic      [WORD_W-1:0] rdata
);
	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/sorted_key_table.sv
// Sorted key table: ascending-key entry store with insert, lookup, remove and clear.
// Clear, insert into a full table and lookup/remove on an empty table strobe done in the
// cycle after start; other operations walk the entry memory one entry per cycle
// (insert walks down from the tail, remove scans then shifts).
// Throughput: one operation at a time; the next start is taken during the done cycle.
// Reset clears the entry count, so the table is empty; the receiver cannot stall results.
`default_nettype none
module sorted_key_table #(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic signed [skt_pkg::KEY_W-1:0] key,
	input  wire logic [skt_pkg::OUT_HDL_W-1:0]    item_handle,
	output logic             done,
	output logic             found,
	output logic [skt_pkg::OUT_HDL_W-1:0]   found_handle,
	output logic [1:0]       status,
	output logic             is_empty,
	output logic [skt_pkg::OUT_COUNT_W-1:0] entry_count
);
	import skt_pkg::*;

	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int HW     = (HANDLE_BITS < OUT_HDL_W) ? HANDLE_BITS : OUT_HDL_W;
	localparam int WORD_W = KEY_W + HW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_INS   = 3'd3;
	localparam logic [2:0] S_WRNEW = 3'd4;

	logic [2:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           idx_q;
	skt_op_t                 op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [HW-1:0]           hdl_q;
	logic                    done_q;
	logic                    found_q;
	logic [OUT_HDL_W-1:0]    fh_q;
	logic [1:0]              status_q;

	logic                    wen;
	logic [AW-1:0]           waddr;
	logic [WORD_W-1:0]       wdata;
	logic [AW-1:0]           raddr;
	logic [WORD_W-1:0]       rdata;
	logic signed [KEY_W-1:0] rkey;
	logic [HW-1:0]           rhdl;
	logic                    at_tail;
	logic                    move_up;
	logic                    key_hit;

	skt_ram #(
		.DEPTH  (DEPTH),
		.AW     (AW),
		.WORD_W (WORD_W)
	) u_ram (
		.clk   (clk),
		.wen   (wen),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rkey    = signed'(rdata[HW +: KEY_W]);
	assign rhdl    = rdata[HW-1:0];
	assign at_tail = (CW'({1'b0, idx_q}) + CW'(1)) == count_q;
	assign key_hit = (rkey == key_q);
	assign move_up = (idx_q != '0) ? (rkey >= key_q) : (key_q < rkey);

	always_comb begin
		wen   = 1'b0;
		waddr = idx_q;
		wdata = {key_q, hdl_q};
		raddr = idx_q + AW'(1);
		case (state_q)
			S_IDLE: begin
				raddr = (func == FUNC_INSERT) ? AW'(count_q - CW'(1)) : '0;
			end
			S_INS: begin
				raddr = idx_q - AW'(1);
				wen   = 1'b1;
				waddr = idx_q + AW'(1);
				wdata = move_up ? rdata : {key_q, hdl_q};
			end
			S_SHIFT: begin
				wen   = 1'b1;
				waddr = idx_q - AW'(1);
				wdata = rdata;
			end
			S_WRNEW: begin
				wen   = 1'b1;
				waddr = '0;
			end
			default: begin
				wen = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_q     <= key;
			hdl_q     <= item_handle[HW-1:0];
		end
		case (state_q)
			S_IDLE: begin
				found_q  <= 1'b0;
				fh_q     <= '0;
				status_q <= STATUS_OK;
				if (func == FUNC_INSERT && count_q == CW'(DEPTH)) begin
					status_q <= STATUS_FULL;
				end else if ((func == FUNC_LOOKUP || func == FUNC_REMOVE) && count_q == '0) begin
					status_q <= STATUS_NOT_FOUND;
				end
			end
			S_SCAN: begin
				if (key_hit) begin
					found_q <= 1'b1;
					fh_q    <= OUT_HDL_W'(rhdl);
				end else if (at_tail) begin
					status_q <= STATUS_NOT_FOUND;
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
			op_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					op_q.shifting <= 1'b0;
					if (start) begin
						op_q.func <= func;
						case (func)
							FUNC_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							FUNC_INSERT: begin
								if (count_q == CW'(DEPTH)) begin
									done_q <= 1'b1;
								end else if (count_q == '0) begin
									state_q <= S_WRNEW;
								end else begin
									idx_q   <= AW'(count_q - CW'(1));
									state_q <= S_INS;
								end
							end
							default: begin
								if (count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									idx_q   <= '0;
									state_q <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_INS: begin
					if (!move_up) begin
						count_q <= count_q + CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (idx_q == '0) begin
						state_q <= S_WRNEW;
					end else begin
						idx_q <= idx_q - AW'(1);
					end
				end
				S_WRNEW: begin
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (key_hit && (op_q.func == FUNC_LOOKUP)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (key_hit && at_tail) begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (key_hit) begin
						op_q.shifting <= 1'b1;
						idx_q         <= idx_q + AW'(1);
						state_q       <= S_SHIFT;
					end else if (at_tail) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_SHIFT: begin
					if (at_tail) begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign found        = found_q;
	assign found_handle = fh_q;
	assign status       = status_q;
	assign is_empty     = (count_q == '0);
	assign entry_count  = OUT_COUNT_W'(count_q);

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wen |-> ({1'b0, waddr} < (AW + 1)'(DEPTH)))
		else $error("entry write outside table");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STATUS_FULL) |-> (count_q == CW'(DEPTH)))
		else $error("full status with room left");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && found_q) |-> (status_q == STATUS_OK))
		else $error("found with error status");

	a_shift_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (op_q.shifting && op_q.func == FUNC_REMOVE))
		else $error("shift outside remove");
`endif
endmodule
`default_nettype wire

// File: tb/tb_sorted_key_table.sv
// Testbench for sorted_key_table: directed and random operations checked against a table tracker.
`timescale 1ns / 100ps
module tb_sorted_key_table;
	import skt_pkg::*;

	localparam int TABLE_DEPTH  = 64;
	localparam int RANDOM_OPS   = 1225;
	localparam int QUIET_TAIL   = 150;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_WAIT  = TABLE_DEPTH + 8;

	typedef struct {
		logic                   found;
		logic [OUT_HDL_W-1:0]   found_handle;
		logic [1:0]             status;
		logic                   is_empty;
		logic [OUT_COUNT_W-1:0] entry_count;
	} op_result_t;

	class sorted_table_tracker;
		logic signed [KEY_W-1:0]  keys [TABLE_DEPTH];
		logic [OUT_HDL_W-1:0]     handles [TABLE_DEPTH];
		int unsigned              count;
		op_result_t               expected_q [$];
		int unsigned              errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function void record_op(logic [1:0] f, logic signed [KEY_W-1:0] k,
				logic [OUT_HDL_W-1:0] h);
			op_result_t  r;
			int unsigned pos;
			int unsigned i;
			r.found        = 1'b0;
			r.found_handle = '0;
			r.status       = STATUS_OK;
			case (f)
				FUNC_INSERT: begin
					if (count >= TABLE_DEPTH) begin
						r.status = STATUS_FULL;
					end else begin
						if (count == 0 || k < keys[0]) begin
							pos = 0;
						end else begin
							pos = 1;
							while (pos < count && keys[pos] < k)
								pos++;
						end
						for (i = count; i > pos; i--) begin
							keys[i]    = keys[i-1];
							handles[i] = handles[i-1];
						end
						keys[pos]    = k;
						handles[pos] = h;
						count++;
					end
				end
				FUNC_LOOKUP, FUNC_REMOVE: begin
					pos = 0;
					while (pos < count && keys[pos] != k)
						pos++;
					if (pos < count) begin
						r.found        = 1'b1;
						r.found_handle = handles[pos];
						if (f == FUNC_REMOVE) begin
							for (i = pos; i + 1 < count; i++) begin
								keys[i]    = keys[i+1];
								handles[i] = handles[i+1];
							end
							count--;
						end
					end else begin
						r.status = STATUS_NOT_FOUND;
					end
				end
				default: begin
					count = 0;
				end
			endcase
			r.is_empty    = (count == 0);
			r.entry_count = count[OUT_COUNT_W-1:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(logic fnd, logic [OUT_HDL_W-1:0] fh, logic [1:0] st,
				logic emp, logic [OUT_COUNT_W-1:0] cnt);
			op_result_t r;
			if (expected_q.size() == 0) begin
				$error("result beat with no operation outstanding");
				errors++;
				return;
			end
			r = expected_q.pop_front();
			if (fnd !== r.found) begin
				$error("found: expected %0d, actual %0d", r.found, fnd);
				errors++;
			end
			if (fh !== r.found_handle) begin
				$error("found_handle: expected 0x%04h, actual 0x%04h", r.found_handle, fh);
				errors++;
			end
			if (st !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, st);
				errors++;
			end
			if (emp !== r.is_empty) begin
				$error("is_empty: expected %0d, actual %0d", r.is_empty, emp);
				errors++;
			end
			if (cnt !== r.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", r.entry_count, cnt);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [1:0]              func = FUNC_CLEAR;
	logic signed [KEY_W-1:0] key = '0;
	logic [OUT_HDL_W-1:0]    item_handle = '0;
	logic                    busy;
	logic                    done;
	logic                    found;
	logic [OUT_HDL_W-1:0]    found_handle;
	logic [1:0]              status;
	logic                    is_empty;
	logic [OUT_COUNT_W-1:0]  entry_count;

	sorted_table_tracker tracker = new();

	sorted_key_table #(
		.DEPTH       (TABLE_DEPTH),
		.HANDLE_BITS (OUT_HDL_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.key          (key),
		.item_handle  (item_handle),
		.done         (done),
		.found        (found),
		.found_handle (found_handle),
		.status       (status),
		.is_empty     (is_empty),
		.entry_count  (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_result(found, found_handle, status, is_empty, entry_count);
			if (start && !busy)
				tracker.record_op(func, key, item_handle);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("sorted_key_table verification failed");
		$finish;
	end

	// called at a rising edge; returns at the edge where the beat is taken
	task automatic send_op(input logic [1:0] f, input logic signed [KEY_W-1:0] k,
			input logic [OUT_HDL_W-1:0] h, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		func        <= f;
		key         <= k;
		item_handle <= h;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 40 && tracker.count > 0)
			return tracker.keys[$urandom_range(0, tracker.count - 1)];
		if (sel < 70)
			return $signed($urandom_range(0, 8)) - 4;
		if (sel < 80) begin
			case ($urandom_range(0, 5))
				0: return 32'sh8000_0000;
				1: return 32'sh8000_0001;
				2: return 32'sh7fff_ffff;
				3: return 32'sh7fff_fffe;
				4: return -1;
				default: return 0;
			endcase
		end
		return $urandom();
	endfunction

	function automatic logic [1:0] pick_func(int mode);
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel == 0)
			return FUNC_CLEAR;
		case (mode)
			0: return (sel < 86) ? FUNC_INSERT : (sel < 95) ? FUNC_LOOKUP : FUNC_REMOVE;
			1: return (sel < 16) ? FUNC_INSERT : (sel < 40) ? FUNC_LOOKUP : FUNC_REMOVE;
			default: return (sel < 40) ? FUNC_INSERT : (sel < 70) ? FUNC_LOOKUP :
				(sel < 96) ? FUNC_REMOVE : FUNC_CLEAR;
		endcase
	endfunction

	initial begin
		int mode;
		int phase_left;
		int gap;
		bit idle_on;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extremes, duplicates, front insert
		send_op(FUNC_LOOKUP, 5, 16'h0000, 0);
		send_op(FUNC_REMOVE, 5, 16'h0000, 0);
		send_op(FUNC_INSERT, 0, 16'h0000, 0);
		send_op(FUNC_INSERT, 32'sh8000_0000, 16'hffff, 0);
		send_op(FUNC_INSERT, 32'sh7fff_ffff, 16'h1234, 0);
		send_op(FUNC_INSERT, -1, 16'h5555, 0);
		send_op(FUNC_INSERT, 0, 16'h00aa, 0);
		send_op(FUNC_INSERT, 32'sh8000_0000, 16'haaaa, 0);
		send_op(FUNC_LOOKUP, 0, 16'hffff, 0);
		send_op(FUNC_LOOKUP, 32'sh8000_0000, 16'h0000, 0);
		send_op(FUNC_LOOKUP, 32'sh7fff_ffff, 16'h0000, 0);
		send_op(FUNC_LOOKUP, 7, 16'h0000, 0);
		send_op(FUNC_REMOVE, 0, 16'h0000, 0);
		send_op(FUNC_REMOVE, 32'sh8000_0000, 16'h0000, 0);
		send_op(FUNC_REMOVE, 7, 16'h0000, 0);
		send_op(FUNC_REMOVE, 32'sh7fff_ffff, 16'h0000, 0);
		send_op(FUNC_CLEAR, 0, 16'h0000, 0);
		send_op(FUNC_INSERT, 100, 16'h0100, 0);
		send_op(FUNC_INSERT, 50, 16'h0050, 0);
		send_op(FUNC_INSERT, 50, 16'h0051, 0);
		send_op(FUNC_INSERT, 75, 16'h0075, 0);
		send_op(FUNC_LOOKUP, 50, 16'h0000, 0);
		send_op(FUNC_REMOVE, 50, 16'h0000, 0);
		send_op(FUNC_CLEAR, 0, 16'h0000, 0);
		send_op(FUNC_LOOKUP, 100, 16'h0000, 0);
		wait_idle();

		mode = 0;
		phase_left = 0;
		idle_on = 1'b1;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (phase_left == 0) begin
				mode = (tracker.count < TABLE_DEPTH / 2) ? $urandom_range(0, 2) :
					$urandom_range(0, 1) ? 1 : $urandom_range(0, 2);
				phase_left = $urandom_range(30, 110);
				idle_on = $urandom_range(0, 2) != 0;
			end
			phase_left--;
			if (n == RANDOM_OPS / 2)
				wait_idle();
			gap = 0;
			if (idle_on && n < RANDOM_OPS - QUIET_TAIL && $urandom_range(0, 3) == 0)
				gap = $urandom_range(1, 15);
			send_op(pick_func(mode), pick_key(), OUT_HDL_W'($urandom_range(0, 16'hffff)), gap);
		end

		start <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (SETTLE_WAIT) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("sorted_key_table verification clean");
		else
			$display("sorted_key_table verification failed");
		$finish;
	end
endmodule
